>>> hw/rtl/pfc_pkg.sv
// Shared types, register indexes and helper functions for the Playfair digraph unit.
// Depends on nothing; imported by playfair_digraph_cipher_unit and its testbench.
package pfc_pkg;

    localparam int SIDE  = 5;
    localparam int CELLS = SIDE * SIDE;
    localparam int LAST  = SIDE - 1;
    localparam int CW    = 8;                   // character width
    localparam int IW    = $clog2(SIDE);        // row / column index width
    localparam int CFG_W = 64;                  // widest configuration register
    localparam int CFG_IW = 3;                  // register index width

    typedef enum logic [CFG_IW-1:0] {
        REG_SQ_0_7   = 3'd0,
        REG_SQ_8_15  = 3'd1,
        REG_SQ_16_23 = 3'd2,
        REG_SQ_24    = 3'd3,
        REG_DIR      = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic              hit;
        logic [IW-1:0]     row;
        logic [IW-1:0]     col;
    } loc_t;

    // stage 1: raw match vectors plus nothing else
    typedef struct packed {
        logic [CELLS-1:0]  match_a;
        logic [CELLS-1:0]  match_b;
    } s1_t;

    // stage 2: target coordinates for both output characters
    typedef struct packed {
        logic              hit;
        logic [IW-1:0]     row_a;
        logic [IW-1:0]     col_a;
        logic [IW-1:0]     row_b;
        logic [IW-1:0]     col_b;
    } s2_t;

    // stage 3: finished result
    typedef struct packed {
        logic              missing;
        logic [CW-1:0]     out_b;
        logic [CW-1:0]     out_a;
    } s3_t;

    // Highest matching position wins.
    function automatic loc_t locate(input logic [CELLS-1:0] m);
        loc_t res;
        logic sel;
        res = '0;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                sel = m[r*SIDE+c] && ((m >> (r*SIDE+c+1)) == '0);
                if (sel) begin
                    res.row = IW'(r);
                    res.col = IW'(c);
                end
            end
        end
        res.hit = |m;
        return res;
    endfunction

    // Move one place with wrap: forward on encrypt, back on decrypt.
    function automatic logic [IW-1:0] wrap_step(input logic [IW-1:0] v, input logic back);
        logic [IW-1:0] res;
        if (back)
            res = (v == '0) ? IW'(LAST) : v - IW'(1);
        else
            res = (v == IW'(LAST)) ? '0 : v + IW'(1);
        return res;
    endfunction

endpackage

>>> hw/rtl/playfair_digraph_cipher_unit.sv
// Top level of the Playfair digraph unit: key square registers and a three-stage pipeline.
// Depends on pfc_pkg (types, register indexes, locate and wrap helpers).
//
//  channel   | direction | width | contents
//  ----------+-----------+-------+---------------------------------------------
//  s_axis    | in        | 16    | tdata: first_char, second_char
//  m_axis    | out       | 16+1  | tdata: first_out, second_out; tuser: missing
//  cfg       | in        | 1+3+64| cfg_we, cfg_index, cfg_data (write only)
//
// One request enters per cycle while m_axis is not stalled; each result passes the stage 1, 2 and 3 registers.
// Stage 1 compares both characters against all 25 square cells, stage 2 encodes
// the last match and applies the row / column / rectangle rule, stage 3 reads the
// target cells and forms the result register that drives m_axis.
// Stalls back up stage by stage; every stage holds its request until the next frees.
// Reset (rst_n low, asynchronous) clears the square, direction and all valid bits.
module playfair_digraph_cipher_unit
    import pfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [2*CW-1:0]      s_axis_tdata,   // [7:0] first_char, [15:8] second_char
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*CW-1:0]      m_axis_tdata,   // [7:0] first_out, [15:8] second_out
    output logic                 m_axis_tuser,   // [0] letter_missing
    input  logic                 cfg_we,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CW-1:0] square_reg [CELLS];
    logic          direction_reg;

    logic v1_reg, v2_reg, v3_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    logic rdy1, rdy2, rdy3;

    // Configuration registers; the user must write them only while the pipeline is empty (not enforced).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < CELLS; p++)
                square_reg[p] <= '0;
            direction_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SQ_0_7:
                begin
                    for (int k = 0; k < 8; k++)
                        square_reg[k] <= cfg_data[CW*k +: CW];
                end
                REG_SQ_8_15:
                begin
                    for (int k = 0; k < 8; k++)
                        square_reg[8+k] <= cfg_data[CW*k +: CW];
                end
                REG_SQ_16_23:
                begin
                    for (int k = 0; k < 8; k++)
                        square_reg[16+k] <= cfg_data[CW*k +: CW];
                end
                REG_SQ_24:
                    square_reg[CELLS-1] <= cfg_data[CW-1:0];
                REG_DIR:
                    direction_reg <= cfg_data[0];
                default:
                    ;   // indexes past the list: drop the write
            endcase
        end
    end

    // Ready chain: a stage takes a request when empty or when it moves on.
    assign rdy3          = !v3_reg || m_axis_tready;
    assign rdy2          = !v2_reg || rdy3;
    assign rdy1          = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    // Stage 1: compare both characters against every cell.
    always_comb
    begin
        for (int p = 0; p < CELLS; p++)
        begin
            s1_next.match_a[p] = (square_reg[p] == s_axis_tdata[CW-1:0]);
            s1_next.match_b[p] = (square_reg[p] == s_axis_tdata[2*CW-1:CW]);
        end
    end

    // Stage 2: encode the last match and pick target coordinates.
    always_comb
    begin
        loc_t la;
        loc_t lb;
        la = locate(s1_reg.match_a);
        lb = locate(s1_reg.match_b);
        s2_next.hit = la.hit && lb.hit;
        if (la.row == lb.row)
        begin
            // same row: shift along the row
            s2_next.row_a = la.row;
            s2_next.col_a = wrap_step(la.col, direction_reg);
            s2_next.row_b = lb.row;
            s2_next.col_b = wrap_step(lb.col, direction_reg);
        end
        else if (la.col == lb.col)
        begin
            // same column: shift along the column
            s2_next.row_a = wrap_step(la.row, direction_reg);
            s2_next.col_a = la.col;
            s2_next.row_b = wrap_step(lb.row, direction_reg);
            s2_next.col_b = lb.col;
        end
        else
        begin
            // rectangle: swap the corner columns
            s2_next.row_a = la.row;
            s2_next.col_a = lb.col;
            s2_next.row_b = lb.row;
            s2_next.col_b = la.col;
        end
    end

    // Stage 3: read the two target cells; zero both when a letter is missing.
    always_comb
    begin
        s3_next.out_a   = '0;
        s3_next.out_b   = '0;
        s3_next.missing = !s2_reg.hit;
        for (int r = 0; r < SIDE; r++)
        begin
            for (int c = 0; c < SIDE; c++)
            begin
                if (s2_reg.hit && s2_reg.row_a == IW'(r) && s2_reg.col_a == IW'(c))
                    s3_next.out_a = square_reg[r*SIDE+c];
                if (s2_reg.hit && s2_reg.row_b == IW'(r) && s2_reg.col_b == IW'(c))
                    s3_next.out_b = square_reg[r*SIDE+c];
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= s_axis_tvalid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // Payload: load only when a stage advances, otherwise hold.
    always_ff @(posedge clk)
    begin
        if (rdy1 && s_axis_tvalid)
            s1_reg <= s1_next;
        if (rdy2 && v1_reg)
            s2_reg <= s2_next;
        if (rdy3 && v2_reg)
            s3_reg <= s3_next;
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {s3_reg.out_b, s3_reg.out_a};
    assign m_axis_tuser  = s3_reg.missing;

`ifndef NO_ASSERTIONS
    // A missing letter always comes out with zero characters.
    a_missing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("missing letter with nonzero output");

    // Input is blocked only when every stage is occupied.
    a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> v1_reg && v2_reg && v3_reg)
        else $error("input blocked with a free stage");

    // A blocked stage 1 keeps its request unchanged.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !rdy2 |=> v1_reg && $stable(s1_reg))
        else $error("stage 1 lost or changed a stalled request");

    // A blocked stage 2 keeps its request unchanged.
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !rdy3 |=> v2_reg && $stable(s2_reg))
        else $error("stage 2 lost or changed a stalled request");

    // Target coordinates stay inside the square.
    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && s2_reg.hit |-> s2_reg.row_a <= IW'(LAST) && s2_reg.col_a <= IW'(LAST)
            && s2_reg.row_b <= IW'(LAST) && s2_reg.col_b <= IW'(LAST))
        else $error("target coordinate outside square");
`endif

endmodule

>>> verif/tb_playfair_digraph_cipher_unit.sv
// Self-checking testbench for playfair_digraph_cipher_unit: random-gap stream driver and
// monitor, an internal Playfair predictor and key-square reprogramming between phases.
// Depends on pfc_pkg and playfair_digraph_cipher_unit.
`timescale 1ns / 1ps

module tb_playfair_digraph_cipher_unit;
    import pfc_pkg::*;

    // Register indexes past the last defined one; writes there must be dropped.
    localparam logic [CFG_IW-1:0] REG_SPARE_LO = 3'd5;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_REQUESTS = 75;

    typedef struct packed {
        logic          missing;
        logic [CW-1:0] second;
        logic [CW-1:0] first;
    } cipher_out_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [2*CW-1:0]      s_axis_tdata = '0;    // [7:0] first_char, [15:8] second_char
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [2*CW-1:0]      m_axis_tdata;         // [7:0] first_out, [15:8] second_out
    logic                 m_axis_tuser;         // [0] letter_missing
    logic                 cfg_we = 1'b0;
    logic [CFG_IW-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Predictor copy of the key square and direction, updated with every register write.
    logic [CW-1:0]        key_sq [CELLS];
    logic                 dir_back;
    logic [CW-1:0]        staged_sq [CELLS];

    logic [2*CW-1:0]      pending_pairs [$];
    cipher_out_t          expected_out [$];

    int                   send_gap;
    int                   recv_gap;
    int                   results_seen = 0;
    int                   errors = 0;
    bit                   no_idle = 1'b0;
    bit                   receiver_hold = 1'b0;

    playfair_digraph_cipher_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Idle length for either side: mostly none, sometimes short, rarely long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Substitute one digraph against the current square. The last matching position
    // wins, so scan upward and keep overwriting.
    function automatic cipher_out_t substitute(input logic [CW-1:0] a, input logic [CW-1:0] b);
        cipher_out_t res;
        int pa;
        int pb;
        int ra;
        int ca;
        int rb;
        int cb;
        int step;
        pa = -1;
        pb = -1;
        res = '0;
        for (int p = 0; p < CELLS; p++)
        begin
            if (key_sq[p] == a)
                pa = p;
            if (key_sq[p] == b)
                pb = p;
        end
        if (pa < 0 || pb < 0)
        begin
            res.missing = 1'b1;
            return res;
        end
        ra = pa / SIDE;
        ca = pa % SIDE;
        rb = pb / SIDE;
        cb = pb % SIDE;
        step = dir_back ? LAST : 1;
        if (ra == rb)
        begin
            // same row, identical characters included: move along the row
            res.first  = key_sq[ra * SIDE + (ca + step) % SIDE];
            res.second = key_sq[rb * SIDE + (cb + step) % SIDE];
        end
        else if (ca == cb)
        begin
            res.first  = key_sq[((ra + step) % SIDE) * SIDE + ca];
            res.second = key_sq[((rb + step) % SIDE) * SIDE + cb];
        end
        else
        begin
            // rectangle: swap columns
            res.first  = key_sq[ra * SIDE + cb];
            res.second = key_sq[rb * SIDE + ca];
        end
        return res;
    endfunction

    // Mirror a register write into the predictor; unknown indexes change nothing.
    function automatic void track_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            REG_SQ_0_7:   for (int k = 0; k < 8; k++) key_sq[k] = data[8*k +: 8];
            REG_SQ_8_15:  for (int k = 0; k < 8; k++) key_sq[8 + k] = data[8*k +: 8];
            REG_SQ_16_23: for (int k = 0; k < 8; k++) key_sq[16 + k] = data[8*k +: 8];
            REG_SQ_24:    key_sq[24] = data[CW-1:0];
            REG_DIR:      dir_back = data[0];
            default:      ;
        endcase
    endfunction

    // Build a request from two square positions.
    function automatic logic [2*CW-1:0] pair_at(input int p, input int q);
        return {key_sq[q], key_sq[p]};
    endfunction

    // Pick a byte that the current square does not hold.
    function automatic logic [CW-1:0] absent_char();
        logic [CW-1:0] c;
        bit found;
        do
        begin
            c = CW'($urandom_range(0, 255));
            found = 1'b0;
            for (int p = 0; p < CELLS; p++)
                if (key_sq[p] == c)
                    found = 1'b1;
        end while (found);
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        track_reg(idx, data);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Load staged_sq into the four square registers; junk goes above the last byte.
    task automatic load_square();
        logic [CFG_W-1:0] word;
        for (int w = 0; w < 3; w++)
        begin
            for (int k = 0; k < 8; k++)
                word[8*k +: 8] = staged_sq[8*w + k];
            write_reg(CFG_IW'(w), word);
        end
        word = {$urandom, $urandom};
        word[CW-1:0] = staged_sq[24];
        write_reg(REG_SQ_24, word);
    endtask

    task automatic set_direction(input logic back);
        logic [CFG_W-1:0] word;
        word = {$urandom, $urandom};
        word[0] = back;
        write_reg(REG_DIR, word);
    endtask

    task automatic random_square(input bit allow_dup);
        bit taken;
        for (int p = 0; p < CELLS; p++)
        begin
            do
            begin
                staged_sq[p] = CW'($urandom_range(0, 255));
                taken = 1'b0;
                for (int q = 0; q < p; q++)
                    if (staged_sq[q] == staged_sq[p])
                        taken = 1'b1;
            end while (taken && !allow_dup);
        end
    endtask

    // Wait until no request is queued, on the bus or in flight, then let the
    // pipeline settle before touching registers.
    task automatic drain();
        do
            @(negedge clk);
        while (pending_pairs.size() != 0 || s_axis_tvalid || expected_out.size() != 0);
        repeat (6) @(posedge clk);
    endtask

    // Mostly pairs drawn from the square (row, column and rectangle cases), some
    // identical characters, the rest noise bytes that may miss the square.
    task automatic queue_random(input int count);
        int p;
        int q;
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            p = $urandom_range(0, CELLS - 1);
            if (r < 25)
                q = (p / SIDE) * SIDE + $urandom_range(0, LAST);
            else if (r < 50)
                q = $urandom_range(0, LAST) * SIDE + p % SIDE;
            else
                q = $urandom_range(0, CELLS - 1);
            if (r < 75)
                pending_pairs.push_back(pair_at(p, q));
            else if (r < 85)
                pending_pairs.push_back(pair_at(p, p));
            else if (r < 92)
                pending_pairs.push_back({absent_char(), key_sq[p]});
            else
                pending_pairs.push_back((2*CW)'($urandom));
        end
    endtask

    // Sender: hold a request until it is taken, then idle for a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_out.push_back(substitute(s_axis_tdata[CW-1:0],
                                                  s_axis_tdata[2*CW-1:CW]));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_pairs.size() != 0)
                begin
                    s_axis_tdata  <= pending_pairs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    send_gap      <= gap_len();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: check every result against the oldest prediction, stall at random.
    always @(posedge clk or negedge rst_n)
    begin : result_check
        cipher_out_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_out.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected: tdata=%h tuser=%b",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (m_axis_tdata[CW-1:0] !== want.first)
                    begin
                        errors++;
                        $display("%0t: first_out expected %h actual %h",
                                 $time, want.first, m_axis_tdata[CW-1:0]);
                    end
                    if (m_axis_tdata[2*CW-1:CW] !== want.second)
                    begin
                        errors++;
                        $display("%0t: second_out expected %h actual %h",
                                 $time, want.second, m_axis_tdata[2*CW-1:CW]);
                    end
                    if (m_axis_tuser !== want.missing)
                    begin
                        errors++;
                        $display("%0t: letter_missing expected %b actual %b",
                                 $time, want.missing, m_axis_tuser);
                    end
                end
            end
            if (receiver_hold)
                m_axis_tready <= 1'b0;
            else if (recv_gap != 0)
            begin
                recv_gap      <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                recv_gap      <= gap_len();
            end
        end
    end

    // Back-pressure: once traffic is flowing, refuse results long enough for the
    // pipeline to fill and push back on the sender.
    initial
    begin
        wait (results_seen >= 50);
        @(posedge clk);
        receiver_hold <= 1'b1;
        repeat (150) @(posedge clk);
        receiver_hold <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb_playfair_digraph_cipher_unit failed");
        $finish;
    end

    initial
    begin
        for (int p = 0; p < CELLS; p++)
            key_sq[p] = '0;
        dir_back = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Out of reset every cell holds zero: zero pairs land on the last cell.
        pending_pairs.push_back({8'h00, 8'h00});
        pending_pairs.push_back({8'h01, 8'h00});
        drain();

        // Classic key square, encrypt.
        // P L A Y F / I R E X M / B C D G H / K N O Q S / T U V W Z
        for (int p = 0; p < CELLS; p++)
            staged_sq[p] = CW'("PLAYFIREXMBCDGHKNOQSTUVWZ" >> (8 * (CELLS - 1 - p)));
        load_square();
        set_direction(1'b0);
        pending_pairs.push_back(pair_at(1, 3));       // same row
        pending_pairs.push_back(pair_at(2, 17));      // same column
        pending_pairs.push_back(pair_at(6, 18));      // rectangle
        pending_pairs.push_back(pair_at(4, 2));       // wrap off the row end
        pending_pairs.push_back(pair_at(21, 6));      // wrap off the column bottom
        pending_pairs.push_back(pair_at(12, 12));     // identical characters
        pending_pairs.push_back({key_sq[5], absent_char()});
        pending_pairs.push_back({absent_char(), key_sq[5]});
        drain();

        // Spare indexes must not disturb the square or direction.
        for (int i = REG_SPARE_LO; i < 2 ** CFG_IW; i++)
            write_reg(CFG_IW'(i), {$urandom, $urandom});
        set_direction(1'b1);
        pending_pairs.push_back(pair_at(7, 8));       // same row
        pending_pairs.push_back(pair_at(10, 12));     // wrap left past column zero
        pending_pairs.push_back(pair_at(0, 15));      // wrap up past row zero
        pending_pairs.push_back(pair_at(3, 21));      // rectangle
        pending_pairs.push_back(pair_at(0, 0));       // identical characters
        drain();

        // Extreme bytes and duplicated cells: the later cell must win.
        random_square(1'b0);
        staged_sq[0]  = 8'hFF;
        staged_sq[24] = 8'h00;
        staged_sq[12] = staged_sq[3];
        staged_sq[19] = staged_sq[7];
        load_square();
        set_direction(1'b0);
        pending_pairs.push_back(pair_at(0, 24));
        pending_pairs.push_back(pair_at(3, 19));
        pending_pairs.push_back(pair_at(12, 12));
        drain();

        // Every register at its maximum.
        for (int p = 0; p < CELLS; p++)
            staged_sq[p] = 8'hFF;
        load_square();
        set_direction(1'b1);
        pending_pairs.push_back({8'hFF, 8'hFF});
        pending_pairs.push_back({8'h00, 8'hFF});
        drain();

        // Random squares and directions; one phase runs without any idling.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            no_idle = (ph == 3);
            random_square(ph % 2 == 1);
            load_square();
            set_direction(ph == 0 ? 1'b0 : (ph == 1 ? 1'b1 : 1'($urandom)));
            queue_random(PHASE_REQUESTS);
            drain();
        end
        no_idle = 1'b0;

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb_playfair_digraph_cipher_unit passed");
        else
            $display("tb_playfair_digraph_cipher_unit failed");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/pfc_pkg.sv
hw/rtl/playfair_digraph_cipher_unit.sv
verif/tb_playfair_digraph_cipher_unit.sv
